// ----- design/gbr_pkg.sv -----
`default_nettype none
package gbr_pkg;
	localparam int GRID_W = 64;
	localparam int GRID_H = 64;
	localparam int XW = 6;
	localparam int YW = 6;
	localparam int IDXW = XW + YW;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int CNTW = IDXW + 1;

	localparam logic [1:0] STS_LOAD = 2'd0;
	localparam logic [1:0] STS_SEARCHED = 2'd1;
	localparam logic [1:0] STS_BLOCKED = 2'd2;
	localparam logic [1:0] STS_DISABLED = 2'd3;

	localparam logic [2:0] NB_N = 3'd0;
	localparam logic [2:0] NB_NE = 3'd1;
	localparam logic [2:0] NB_E = 3'd2;
	localparam logic [2:0] NB_SE = 3'd3;
	localparam logic [2:0] NB_S = 3'd4;
	localparam logic [2:0] NB_SW = 3'd5;
	localparam logic [2:0] NB_W = 3'd6;
	localparam logic [2:0] NB_NW = 3'd7;

	localparam logic [IDXW-1:0] ROW_STEP = IDXW'(GRID_W);
	localparam logic [XW-1:0] X_LAST = XW'(GRID_W - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(GRID_H - 1);

	typedef struct packed {
		logic [1:0] n;
		logic [1:0] e;
		logic [1:0] s;
		logic [1:0] w;
	} nbr_flags_t;
endpackage
`default_nettype wire

// ----- design/gbr_nbr.sv -----
`default_nettype none
module gbr_nbr
	import gbr_pkg::*;
(
	input  wire logic [IDXW-1:0] cur,
	input  wire logic [2:0]      sel,
	input  wire nbr_flags_t      flags,
	output logic [IDXW-1:0]      nb_idx,
	output logic                 ok
);
	logic [XW-1:0] x;
	logic [YW-1:0] y;
	logic has_n, has_s, has_e, has_w;

	function automatic logic corner(input logic [1:0] v, input logic [1:0] h);
		corner = (!v[1] && !h[0]) || (!v[0] && !h[1]);
	endfunction

	assign x = cur[XW-1:0];
	assign y = cur[IDXW-1:XW];
	assign has_n = (y != '0);
	assign has_s = (y != Y_LAST);
	assign has_w = (x != '0);
	assign has_e = (x != X_LAST);

	always_comb begin
		unique case (sel)
			NB_N: begin
				nb_idx = cur - ROW_STEP;
				ok = has_n && !flags.n[0];
			end
			NB_NE: begin
				nb_idx = cur - ROW_STEP + IDXW'(1);
				ok = has_n && has_e && corner(flags.n, flags.e);
			end
			NB_E: begin
				nb_idx = cur + IDXW'(1);
				ok = has_e && !flags.e[1];
			end
			NB_SE: begin
				nb_idx = cur + ROW_STEP + IDXW'(1);
				ok = has_s && has_e && corner(flags.s, flags.e);
			end
			NB_S: begin
				nb_idx = cur + ROW_STEP;
				ok = has_s && !flags.s[0];
			end
			NB_SW: begin
				nb_idx = cur + ROW_STEP - IDXW'(1);
				ok = has_s && has_w && corner(flags.s, flags.w);
			end
			NB_W: begin
				nb_idx = cur - IDXW'(1);
				ok = has_w && !flags.w[1];
			end
			NB_NW: begin
				nb_idx = cur - ROW_STEP - IDXW'(1);
				ok = has_n && has_w && corner(flags.n, flags.w);
			end
			default: begin
				nb_idx = cur;
				ok = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- design/grid_bfs_reachability_top.sv -----
// Reachability search on a 64 x 64 grid map with 8-connected moves.
// Input channel in_valid / in_stall carries one item per transfer. A load
// item (req_type 0) writes one cell's north-south and east-west flags; a
// query item (req_type 1) floods outward from the start cell and reports
// whether the end cell is reached. Every item gives one result on the
// out_valid / out_stall channel: reachable and status (0 load done,
// 1 searched, 2 start or end blocked, 3 not enabled).
// A load goes straight to its result; a query first checks the start and end
// cells. A searching query pops each cell, reads its side neighbors' flags and
// tests its eight neighbors, then sweeps the visited store clear; the worst
// case is set by the single read
// port of the obstacle, visited and queue memories.
// After reset the block clears the obstacle and
// visited memories and holds in_stall high meanwhile.
// A finished result sits in the output register until taken; while out_stall
// is high the next item is still accepted and runs, and its result waits
// for the register to free.
`default_nettype none
module grid_bfs_reachability_top
	import gbr_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          req_type,
	input  wire logic [XW-1:0] cell_x,
	input  wire logic [YW-1:0] cell_y,
	input  wire logic          ns_block,
	input  wire logic          ew_block,
	input  wire logic [XW-1:0] start_x,
	input  wire logic [YW-1:0] start_y,
	input  wire logic [XW-1:0] end_x,
	input  wire logic [YW-1:0] end_y,
	input  wire logic          run_enable,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               reachable,
	output logic [1:0]         status
);
	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHKS  = 4'd2;
	localparam logic [3:0] S_CHKE  = 4'd3;
	localparam logic [3:0] S_CHKD  = 4'd4;
	localparam logic [3:0] S_POP   = 4'd5;
	localparam logic [3:0] S_POPD  = 4'd6;
	localparam logic [3:0] S_RDNB  = 4'd7;
	localparam logic [3:0] S_NB    = 4'd8;
	localparam logic [3:0] S_NBV   = 4'd9;
	localparam logic [3:0] S_SWEEP = 4'd10;
	localparam logic [3:0] S_RESP  = 4'd11;

	logic [3:0] state_q;
	logic [IDXW-1:0] si_q, ei_q, cur_q, clr_q;
	logic en_q, sbad_q, found_q;
	logic [CNTW-1:0] head_q, tail_q;
	logic [2:0] rd_q, sel_q;
	nbr_flags_t flags_q;
	logic res_reach_q;
	logic [1:0] res_status_q;
	logic out_valid_q, reach_q;
	logic [1:0] status_q;

	logic [1:0] obs_mem [CELLS];
	logic vis_mem [CELLS];
	logic [IDXW-1:0] q_mem [CELLS];

	logic obs_we, vis_we, vis_wdata, q_we;
	logic [IDXW-1:0] obs_waddr, obs_raddr, vis_waddr, vis_raddr, q_waddr, q_raddr, q_wdata;
	logic [1:0] obs_wdata, obs_rdata_q;
	logic vis_rdata_q;
	logic [IDXW-1:0] q_rdata_q;

	logic [IDXW-1:0] nb_idx;
	logic nb_ok;
	logic out_free;

	gbr_nbr u_nbr (
		.cur    (cur_q),
		.sel    (sel_q),
		.flags  (flags_q),
		.nb_idx (nb_idx),
		.ok     (nb_ok)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign reachable = reach_q;
	assign status = status_q;

	always_comb begin
		obs_we = 1'b0;
		obs_waddr = {cell_y, cell_x};
		obs_wdata = {ew_block, ns_block};
		obs_raddr = si_q;
		vis_we = 1'b0;
		vis_waddr = nb_idx;
		vis_wdata = 1'b1;
		vis_raddr = nb_idx;
		q_we = 1'b0;
		q_waddr = tail_q[IDXW-1:0];
		q_wdata = nb_idx;
		q_raddr = head_q[IDXW-1:0];
		unique case (state_q)
			S_INIT: begin
				obs_we = 1'b1;
				obs_waddr = clr_q;
				obs_wdata = 2'b00;
				vis_we = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			S_IDLE: obs_we = in_valid && !req_type;
			S_CHKE: obs_raddr = ei_q;
			S_CHKD: begin
				if (!sbad_q && obs_rdata_q == 2'b00 && en_q) begin
					vis_we = 1'b1;
					vis_waddr = si_q;
					q_we = 1'b1;
					q_waddr = '0;
					q_wdata = si_q;
				end
			end
			S_RDNB: begin
				case (rd_q)
					3'd0: obs_raddr = cur_q - ROW_STEP;
					3'd1: obs_raddr = cur_q + IDXW'(1);
					3'd2: obs_raddr = cur_q + ROW_STEP;
					default: obs_raddr = cur_q - IDXW'(1);
				endcase
			end
			S_NBV: begin
				if (!vis_rdata_q) begin
					vis_we = 1'b1;
					q_we = (tail_q < CNTW'(CELLS));
				end
			end
			S_SWEEP: begin
				vis_we = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (obs_we) begin
			obs_mem[obs_waddr] <= obs_wdata;
		end
		obs_rdata_q <= obs_mem[obs_raddr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rdata_q <= vis_mem[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		q_rdata_q <= q_mem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			rd_q <= '0;
			sel_q <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + IDXW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						si_q <= {start_y, start_x};
						ei_q <= {end_y, end_x};
						en_q <= run_enable;
						res_reach_q <= 1'b0;
						res_status_q <= STS_LOAD;
						state_q <= req_type ? S_CHKS : S_RESP;
					end
				end
				S_CHKS: state_q <= S_CHKE;
				S_CHKE: begin
					sbad_q <= (obs_rdata_q != 2'b00);
					state_q <= S_CHKD;
				end
				S_CHKD: begin
					if (sbad_q || obs_rdata_q != 2'b00) begin
						res_status_q <= STS_BLOCKED;
						state_q <= S_RESP;
					end else if (!en_q) begin
						res_status_q <= STS_DISABLED;
						state_q <= S_RESP;
					end else begin
						res_status_q <= STS_SEARCHED;
						head_q <= '0;
						tail_q <= CNTW'(1);
						found_q <= 1'b0;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (head_q < tail_q) begin
						head_q <= head_q + CNTW'(1);
						state_q <= S_POPD;
					end else begin
						clr_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_POPD: begin
					cur_q <= q_rdata_q;
					if (q_rdata_q == ei_q) begin
						found_q <= 1'b1;
						clr_q <= '0;
						state_q <= S_SWEEP;
					end else begin
						rd_q <= '0;
						state_q <= S_RDNB;
					end
				end
				S_RDNB: begin
					rd_q <= rd_q + 3'd1;
					case (rd_q)
						3'd1: flags_q.n <= obs_rdata_q;
						3'd2: flags_q.e <= obs_rdata_q;
						3'd3: flags_q.s <= obs_rdata_q;
						3'd4: flags_q.w <= obs_rdata_q;
						default: ;
					endcase
					if (rd_q == 3'd4) begin
						sel_q <= NB_N;
						state_q <= S_NB;
					end
				end
				S_NB: begin
					if (nb_ok) begin
						state_q <= S_NBV;
					end else begin
						sel_q <= sel_q + 3'd1;
						if (sel_q == NB_NW) begin
							state_q <= S_POP;
						end
					end
				end
				S_NBV: begin
					if (!vis_rdata_q && tail_q < CNTW'(CELLS)) begin
						tail_q <= tail_q + CNTW'(1);
					end
					sel_q <= sel_q + 3'd1;
					state_q <= (sel_q == NB_NW) ? S_POP : S_NB;
				end
				S_SWEEP: begin
					clr_q <= clr_q + IDXW'(1);
					if (clr_q == '1) begin
						res_reach_q <= found_q;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			reach_q <= res_reach_q;
			status_q <= res_status_q;
		end
	end

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CNTW'(CELLS))
		else $error("frontier tail beyond grid size");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("frontier head passed tail");

	a_load_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_LOAD |-> !reachable)
		else $error("load result flagged reachable");

	a_resp_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_RESP)
		else $error("result raised outside response state");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import gbr_pkg::*;

	typedef struct packed {
		logic          req_type;
		logic [XW-1:0] cell_x;
		logic [YW-1:0] cell_y;
		logic          ns_block;
		logic          ew_block;
		logic [XW-1:0] start_x;
		logic [YW-1:0] start_y;
		logic [XW-1:0] end_x;
		logic [YW-1:0] end_y;
		logic          run_enable;
	} grid_req_t;

	typedef struct packed {
		logic       reachable;
		logic [1:0] status;
	} grid_ans_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	grid_req_t cur;
	logic out_valid;
	logic out_stall;
	logic reachable;
	logic [1:0] status;

	grid_req_t pending_reqs[$];
	grid_ans_t expected_answers[$];
	logic [1:0] flag_map[CELLS];
	logic seen_map[CELLS];
	logic [IDXW-1:0] frontier[CELLS];
	int errors;
	int sent;
	int total;
	bit stim_done;
	bit hold_off;
	int gap;
	int ostall;

	grid_bfs_reachability_top DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(cur.req_type), .cell_x(cur.cell_x), .cell_y(cur.cell_y),
		.ns_block(cur.ns_block), .ew_block(cur.ew_block),
		.start_x(cur.start_x), .start_y(cur.start_y),
		.end_x(cur.end_x), .end_y(cur.end_y), .run_enable(cur.run_enable),
		.out_valid(out_valid), .out_stall(out_stall),
		.reachable(reachable), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit corner_clear(int v, int h);
		return (!flag_map[v][1] && !flag_map[h][0]) || (!flag_map[v][0] && !flag_map[h][1]);
	endfunction

	function automatic bit flood_reaches(int src, int dst);
		int head;
		int tail;
		int c;
		int x;
		int y;
		int cand[8];
		bit ok[8];
		bit found;
		head = 0;
		tail = 1;
		found = 0;
		foreach (seen_map[i]) seen_map[i] = 1'b0;
		seen_map[src] = 1'b1;
		frontier[0] = IDXW'(src);
		while (head < tail) begin
			c = frontier[head];
			head++;
			if (c == dst) begin
				found = 1;
				break;
			end
			x = c % GRID_W;
			y = c / GRID_W;
			cand = '{c - GRID_W, c - GRID_W + 1, c + 1, c + GRID_W + 1,
				c + GRID_W, c + GRID_W - 1, c - 1, c - GRID_W - 1};
			ok[0] = y > 0 && !flag_map[c - GRID_W][0];
			ok[1] = y > 0 && x < GRID_W - 1 && corner_clear(c - GRID_W, c + 1);
			ok[2] = x < GRID_W - 1 && !flag_map[c + 1][1];
			ok[3] = y < GRID_H - 1 && x < GRID_W - 1 && corner_clear(c + GRID_W, c + 1);
			ok[4] = y < GRID_H - 1 && !flag_map[c + GRID_W][0];
			ok[5] = y < GRID_H - 1 && x > 0 && corner_clear(c + GRID_W, c - 1);
			ok[6] = x > 0 && !flag_map[c - 1][1];
			ok[7] = y > 0 && x > 0 && corner_clear(c - GRID_W, c - 1);
			for (int k = 0; k < 8; k++) begin
				if (ok[k] && !seen_map[cand[k]]) begin
					seen_map[cand[k]] = 1'b1;
					frontier[tail] = IDXW'(cand[k]);
					tail++;
				end
			end
		end
		return found;
	endfunction

	function automatic grid_ans_t predict_answer(grid_req_t r);
		grid_ans_t a;
		int si;
		int ei;
		a = '{reachable: 1'b0, status: STS_LOAD};
		if (r.req_type == REQ_LOAD) begin
			flag_map[int'(r.cell_y) * GRID_W + int'(r.cell_x)] = {r.ew_block, r.ns_block};
		end else begin
			si = int'(r.start_y) * GRID_W + int'(r.start_x);
			ei = int'(r.end_y) * GRID_W + int'(r.end_x);
			if (flag_map[si] != 2'b00 || flag_map[ei] != 2'b00) begin
				a.status = STS_BLOCKED;
			end else if (!r.run_enable) begin
				a.status = STS_DISABLED;
			end else begin
				a.status = STS_SEARCHED;
				a.reachable = flood_reaches(si, ei);
			end
		end
		return a;
	endfunction

	function automatic grid_req_t load_req(int x, int y, bit ns, bit ew);
		grid_req_t r;
		r = grid_req_t'(40'({$urandom, $urandom}));
		r.req_type = REQ_LOAD;
		r.cell_x = XW'(x);
		r.cell_y = YW'(y);
		r.ns_block = ns;
		r.ew_block = ew;
		return r;
	endfunction

	function automatic grid_req_t query_req(int sx, int sy, int ex, int ey, bit en);
		grid_req_t r;
		r = grid_req_t'(40'({$urandom, $urandom}));
		r.req_type = REQ_QUERY;
		r.start_x = XW'(sx);
		r.start_y = YW'(sy);
		r.end_x = XW'(ex);
		r.end_y = YW'(ey);
		r.run_enable = en;
		return r;
	endfunction

	function automatic void add_req(grid_req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	initial begin
		int x;
		int y;
		foreach (flag_map[i]) flag_map[i] = 2'b00;
		// open map, then a blocked far corner
		add_req(query_req(0, 0, 63, 63, 1'b1));
		add_req(query_req(5, 5, 5, 5, 1'b1));
		add_req(query_req(5, 5, 5, 5, 1'b0));
		add_req(query_req(63, 0, 0, 63, 1'b0));
		add_req(load_req(63, 63, 1, 0));
		add_req(query_req(0, 0, 63, 63, 1'b1));
		add_req(query_req(63, 63, 0, 0, 1'b0));
		add_req(load_req(63, 63, 0, 1));
		add_req(query_req(0, 0, 63, 63, 1'b1));
		add_req(load_req(63, 63, 0, 0));
		// enclose (0,0): east neighbor ew, south ns, diagonal corners closed
		add_req(load_req(1, 0, 1, 1));
		add_req(load_req(0, 1, 1, 1));
		add_req(query_req(0, 0, 63, 63, 1'b1));
		add_req(load_req(1, 0, 1, 0));
		add_req(query_req(0, 0, 2, 2, 1'b1));
		add_req(load_req(1, 0, 0, 0));
		add_req(load_req(0, 1, 0, 0));
		add_req(query_req(0, 63, 63, 0, 1'b1));
		// random: mostly wall loads interleaved with queries
		for (int i = 0; i < 82; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				x = $urandom_range(0, 63);
				y = $urandom_range(0, 63);
				if ($urandom_range(0, 3) == 0) begin
					x = $urandom_range(0, 1) ? 0 : 63;
				end
				add_req(load_req(x, y, $urandom_range(0, 1),
					$urandom_range(0, 1)));
			end else begin
				add_req(query_req($urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 5) != 0));
			end
		end
		total = pending_reqs.size();
		foreach (pending_reqs[i])
			expected_answers = {expected_answers, predict_answer(pending_reqs[i])};
		foreach (flag_map[i]) flag_map[i] = 2'b00;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cur <= '0;
			sent = 0;
			gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (sent < total) begin
					in_valid <= 1'b1;
					cur <= pending_reqs[sent];
					gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
						$urandom_range(0, 2);
					if ($urandom_range(0, 2) == 0) gap = 0;
				end else begin
					in_valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (sent >= 4);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			ostall = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected result", status, 0);
				end else begin
					if (reachable !== expected_answers[0].reachable)
						report_mismatch("reachable", reachable, expected_answers[0].reachable);
					if (status !== expected_answers[0].status)
						report_mismatch("status", status, expected_answers[0].status);
					void'(expected_answers.pop_front());
				end
			end
			if (ostall > 0) ostall--;
			else if ($urandom_range(0, 3) == 0)
				ostall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
					$urandom_range(1, 3);
			out_stall <= hold_off || ostall > 0;
		end
	end

	initial begin
		wait (stim_done && expected_answers.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1000ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
